// ===== design/nve_pkg.sv =====
`default_nettype none

package nve_pkg;

    // Event codes carried in the kind field.
    localparam logic [2:0] KIND_ENTER   = 3'd0;
    localparam logic [2:0] KIND_UP      = 3'd1;
    localparam logic [2:0] KIND_DOWN    = 3'd2;
    localparam logic [2:0] KIND_BUTTON  = 3'd3;
    localparam logic [2:0] KIND_RUN     = 3'd4;
    localparam logic [2:0] KIND_PREVIEW = 3'd5;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MIN_VALUE      = 2'd0;
    localparam logic [1:0] CFG_MAX_VALUE      = 2'd1;
    localparam logic [1:0] CFG_DOT_POSITION   = 2'd2;
    localparam logic [1:0] CFG_DISPLAY_DIGITS = 2'd3;

    localparam logic [15:0] MIN_VALUE_RESET = 16'd0;
    localparam logic [15:0] MAX_VALUE_RESET = 16'd9999;
    localparam logic [1:0]  DOT_RESET       = 2'd0;
    localparam logic [2:0]  DIGITS_FOUR     = 3'd4;

    // Decimal thresholds and edit increments.
    localparam logic [15:0] TEN_THOUSAND = 16'd10000;
    localparam logic [15:0] ONE_THOUSAND = 16'd1000;

    // Reciprocals scaled by 2^32, rounded up; exact quotients for any 16-bit dividend.
    localparam logic [31:0] RECIP_10    = 32'((64'd1 << 32) / 64'd10    + 64'd1);
    localparam logic [31:0] RECIP_100   = 32'((64'd1 << 32) / 64'd100   + 64'd1);
    localparam logic [31:0] RECIP_1000  = 32'((64'd1 << 32) / 64'd1000  + 64'd1);
    localparam logic [31:0] RECIP_10000 = 32'((64'd1 << 32) / 64'd10000 + 64'd1);

    // Formatted display fields; digit[0] is the leftmost digit.
    typedef struct packed {
        logic [3:0][3:0] digit;
        logic            dot_shown;
        logic [1:0]      dot_place;
    } nve_disp_t;

endpackage

`default_nettype wire

// ===== design/nve_display.sv =====
`default_nettype none

// Turns a 16-bit value into auto-scaled decimal digits and a point position.
module nve_display
    import nve_pkg::*;
(
    input  wire logic [15:0] value,
    input  wire logic [1:0]  dot_position,
    input  wire logic        four_digits,
    output nve_disp_t        disp
);

    logic [15:0] q1, q2, q3, q4;
    logic [3:0]  d0, d1, d2, d3, d4;
    logic [1:0]  shift;
    logic [1:0]  dot_diff;
    logic        dot_ok;

    // All quotients come from independent constant multiplies.
    assign q1 = 16'((48'(value) * 48'(RECIP_10))    >> 32);
    assign q2 = 16'((48'(value) * 48'(RECIP_100))   >> 32);
    assign q3 = 16'((48'(value) * 48'(RECIP_1000))  >> 32);
    assign q4 = 16'((48'(value) * 48'(RECIP_10000)) >> 32);

    assign d0 = 4'(value - 16'(q1 * 16'd10));
    assign d1 = 4'(q1 - 16'(q2 * 16'd10));
    assign d2 = 4'(q2 - 16'(q3 * 16'd10));
    assign d3 = 4'(q3 - 16'(q4 * 16'd10));
    assign d4 = q4[3:0];

    always_comb
    begin
        if (four_digits)
        begin
            shift = (value >= TEN_THOUSAND) ? 2'd1 : 2'd0;
        end
        else if (value >= TEN_THOUSAND)
        begin
            shift = 2'd2;
        end
        else if (value >= ONE_THOUSAND)
        begin
            shift = 2'd1;
        end
        else
        begin
            shift = 2'd0;
        end
    end

    // The point falls off once scaling pushes it below the rightmost place.
    assign dot_diff = dot_position - shift;
    assign dot_ok   = (dot_position >= shift) && (four_digits || dot_diff != 2'd3);

    always_comb
    begin
        case ({four_digits, shift})
            3'b100:  disp.digit = {d0, d1, d2, d3};
            3'b101:  disp.digit = {d1, d2, d3, d4};
            3'b000:  disp.digit = {4'd0, d0, d1, d2};
            3'b001:  disp.digit = {4'd0, d1, d2, d3};
            3'b010:  disp.digit = {4'd0, d2, d3, d4};
            default: disp.digit = '0;
        endcase
        disp.dot_shown = dot_ok;
        disp.dot_place = dot_ok ? dot_diff : 2'd0;
    end

endmodule

`default_nettype wire

// ===== design/encoder_numeric_value_editor.sv =====
`default_nettype none

// Numeric value editor for a front panel, driven by encoder events. Each input
// transaction carries one event and produces exactly one result transaction.
// The block is a two-register pipeline: an event is captured in an input
// register, and then the value update and the decimal formatting are worked
// out in a single pass into the result register. One transaction is taken
// in every cycle while in_stall is low, and a stalled result holds the
// pipeline only once the input register is also full. The configuration port
// is always ready and should only be written while no events are in flight.
// Digits are given leftmost first and are auto-scaled to three or four
// places, moving the decimal point left by one place for every division by ten.
module encoder_numeric_value_editor
    import nve_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  kind,
    input  wire logic [15:0] stored_value,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             display_update,
    output logic [3:0]       digit_0,
    output logic [3:0]       digit_1,
    output logic [3:0]       digit_2,
    output logic [3:0]       digit_3,
    output logic             dot_shown,
    output logic [1:0]       dot_place,
    output logic             fine_step,
    output logic             commit,
    output logic [15:0]      commit_value,
    output logic             leave,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    // Configuration registers.
    logic [15:0] min_value_reg;
    logic [15:0] max_value_reg;
    logic [1:0]  dot_position_reg;
    logic        four_digits_reg;

    // Editor state.
    logic [15:0] edit_value_reg, edit_value_next;
    logic        fine_phase_reg, fine_phase_next;

    // Input register stage.
    logic        s1_valid_reg, s1_valid_next;
    logic [2:0]  kind_reg;
    logic [15:0] stored_reg;

    // Result register stage.
    logic        out_valid_reg, out_valid_next;
    logic        display_update_reg;
    nve_disp_t   disp_reg;
    logic        fine_step_reg;
    logic        commit_reg;
    logic [15:0] commit_value_reg;
    logic        leave_reg;

    logic        in_accept;
    logic        s1_advance;

    logic [9:0]  inc;
    logic [16:0] up_sum;
    logic [16:0] down_floor;
    logic [15:0] up_value;
    logic [15:0] down_value;

    logic        show;
    logic [15:0] show_value;
    logic        do_commit;
    logic        do_leave;
    nve_disp_t   disp;

    // The first stage moves on whenever the result register is empty or is
    // being emptied in this cycle, so a full pipeline still flows each cycle.
    assign s1_advance = s1_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall   = s1_valid_reg && out_valid_reg && out_stall;
    assign in_accept  = in_valid && !in_stall;

    assign s1_valid_next  = in_accept || (s1_valid_reg && !s1_advance);
    assign out_valid_next = s1_advance || (out_valid_reg && out_stall);

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_value_reg    <= MIN_VALUE_RESET;
            max_value_reg    <= MAX_VALUE_RESET;
            dot_position_reg <= DOT_RESET;
            four_digits_reg  <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MIN_VALUE:      min_value_reg    <= cfg_data;
                CFG_MAX_VALUE:      max_value_reg    <= cfg_data;
                CFG_DOT_POSITION:   dot_position_reg <= cfg_data[1:0];
                CFG_DISPLAY_DIGITS: four_digits_reg  <= (cfg_data[2:0] == DIGITS_FOUR);
                default:            four_digits_reg  <= four_digits_reg;
            endcase
        end
    end

    // The increment grows with the magnitude of the value and is ten times
    // larger in the coarse phase.
    always_comb
    begin
        if (edit_value_reg >= TEN_THOUSAND)
        begin
            inc = fine_phase_reg ? 10'd100 : 10'd1000;
        end
        else if (edit_value_reg >= ONE_THOUSAND)
        begin
            inc = fine_phase_reg ? 10'd10 : 10'd100;
        end
        else
        begin
            inc = fine_phase_reg ? 10'd1 : 10'd10;
        end
    end

    // Limit tests are done one bit wider so that nothing wraps; reaching
    // the limit, or passing it, lands exactly on it.
    assign up_sum     = 17'(edit_value_reg) + 17'(inc);
    assign up_value   = (up_sum < {1'b0, max_value_reg}) ? up_sum[15:0] : max_value_reg;
    assign down_floor = 17'(min_value_reg) + 17'(inc);
    assign down_value = ({1'b0, edit_value_reg} > down_floor)
                        ? edit_value_reg - 16'(inc) : min_value_reg;

    always_comb
    begin
        edit_value_next = edit_value_reg;
        fine_phase_next = fine_phase_reg;
        show            = 1'b0;
        show_value      = edit_value_reg;
        do_commit       = 1'b0;
        do_leave        = 1'b0;
        case (kind_reg)
            KIND_ENTER:
            begin
                edit_value_next = stored_reg;
                fine_phase_next = 1'b0;
                show            = 1'b1;
                show_value      = stored_reg;
            end
            KIND_UP:
            begin
                edit_value_next = up_value;
                show            = 1'b1;
                show_value      = up_value;
            end
            KIND_DOWN:
            begin
                edit_value_next = down_value;
                show            = 1'b1;
                show_value      = down_value;
            end
            KIND_BUTTON:
            begin
                if (!fine_phase_reg)
                begin
                    fine_phase_next = 1'b1;
                    show            = 1'b1;
                end
                else
                begin
                    do_commit = 1'b1;
                    do_leave  = 1'b1;
                end
            end
            KIND_RUN:
            begin
                do_leave = 1'b1;
            end
            KIND_PREVIEW:
            begin
                show       = 1'b1;
                show_value = stored_reg;
            end
            default:
            begin
                show = 1'b0;
            end
        endcase
    end

    nve_display u_display (
        .value        (show_value),
        .dot_position (dot_position_reg),
        .four_digits  (four_digits_reg),
        .disp         (disp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            edit_value_reg <= 16'd0;
            fine_phase_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_advance)
            begin
                edit_value_reg <= edit_value_next;
                fine_phase_reg <= fine_phase_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            kind_reg   <= kind;
            stored_reg <= stored_value;
        end
        if (s1_advance)
        begin
            display_update_reg <= show;
            disp_reg           <= show ? disp : '0;
            fine_step_reg      <= fine_phase_next;
            commit_reg         <= do_commit;
            commit_value_reg   <= do_commit ? edit_value_reg : 16'd0;
            leave_reg          <= do_leave;
        end
    end

    assign out_valid      = out_valid_reg;
    assign display_update = display_update_reg;
    assign digit_0        = disp_reg.digit[0];
    assign digit_1        = disp_reg.digit[1];
    assign digit_2        = disp_reg.digit[2];
    assign digit_3        = disp_reg.digit[3];
    assign dot_shown      = disp_reg.dot_shown;
    assign dot_place      = disp_reg.dot_place;
    assign fine_step      = fine_step_reg;
    assign commit         = commit_reg;
    assign commit_value   = commit_value_reg;
    assign leave          = leave_reg;

    // A commit always closes the editor.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && commit_reg |-> leave_reg)
        else $error("commit without leave");

    // Leaving never comes with a display update.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && leave_reg |-> !display_update_reg)
        else $error("display update on leave");

    // Only an encoder button press can move the editor into the fine phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(fine_phase_reg) |-> $past(s1_advance && kind_reg == KIND_BUTTON))
        else $error("fine phase entered without button press");

    // Every shown digit is a decimal digit.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && display_update_reg |->
            disp_reg.digit[0] <= 4'd9 && disp_reg.digit[1] <= 4'd9 &&
            disp_reg.digit[2] <= 4'd9 && disp_reg.digit[3] <= 4'd9)
        else $error("digit out of decimal range");

endmodule

`default_nettype wire
